// ===== design/ray_march_column_caster_macros.svh =====
// ----------------------------------------------------------------------------
// ray_march_column_caster_macros
// Assertion macros used by the caster's controller.
// ----------------------------------------------------------------------------
`ifndef RAY_MARCH_COLUMN_CASTER_MACROS_SVH
`define RAY_MARCH_COLUMN_CASTER_MACROS_SVH

// same-cycle implication
`define RMCC_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("rmcc assertion failed");

// next-cycle implication
`define RMCC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("rmcc assertion failed");

`endif

// ===== design/rmcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rmcc_pkg
// Constants, types and trig tables for the ray march column caster.
// ----------------------------------------------------------------------------
package rmcc_pkg;

  localparam int MAP_WIDTH     = 16;
  localparam int MAP_HEIGHT    = 8;
  localparam int WINDOW_WIDTH  = 40;
  localparam int WINDOW_HEIGHT = 24;
  localparam int ANGLE_STEPS   = 241;
  localparam int MAX_STEPS     = 64;
  localparam int MAP_CELLS     = MAP_WIDTH * MAP_HEIGHT;

  localparam int CELL_W  = 7;
  localparam int VAL_W   = 8;
  localparam int COL_W   = 6;
  localparam int POS_W   = 12;
  localparam int ANG_W   = 8;
  localparam int TRIG_W  = 16;
  localparam int ACC_W   = 22;
  localparam int PX_W    = 17;
  localparam int K_W     = 7;
  localparam int SHADE_W = 2;
  localparam int CEIL_W  = 4;
  localparam int FLOOR_W = 5;
  localparam int REM_W   = 12;
  localparam int DEN_W   = 8;
  localparam int DIV_STEPS = 4;
  localparam int CNT_W   = 2;

  localparam logic [VAL_W-1:0] WALL_CODE = 8'h0A;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef enum logic [1:0] {
    CFG_PLAYER_X     = 2'd0,
    CFG_PLAYER_Y     = 2'd1,
    CFG_PLAYER_ANGLE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic accept_write;
    logic accept_cast;
    logic load_angle;
    logic march;
    logic div_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic march_done;
    logic div_last;
  } dp_status_t;

  typedef logic signed [TRIG_W-1:0] trig_rom_t [ANGLE_STEPS];

  function automatic logic signed [TRIG_W-1:0] quarter_sine(input int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x    = (64'(r) * HALF_PI_Q30) / 64'(ANGLE_STEPS);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = 0;
    return TRIG_W'((64'(sum) + 64'd32768) >> 16);
  endfunction

  function automatic trig_rom_t build_rom(input logic want_sin);
    trig_rom_t t;
    int unsigned q;
    int unsigned r;
    logic signed [TRIG_W-1:0] s_r;
    logic signed [TRIG_W-1:0] s_c;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      q   = (4 * i) / ANGLE_STEPS;
      r   = (4 * i) % ANGLE_STEPS;
      s_r = quarter_sine(r);
      s_c = quarter_sine(ANGLE_STEPS - r);
      case (q % 4)
        0:       t[i] = want_sin ? s_r : s_c;
        1:       t[i] = want_sin ? s_c : -s_r;
        2:       t[i] = want_sin ? -s_r : -s_c;
        default: t[i] = want_sin ? -s_c : s_r;
      endcase
    end
    return t;
  endfunction

  localparam trig_rom_t SIN_ROM = build_rom(1'b1);
  localparam trig_rom_t COS_ROM = build_rom(1'b0);

endpackage

// ===== design/rmcc_ram.sv =====
// ----------------------------------------------------------------------------
// rmcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmcc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rmcc_dp.sv =====
// ----------------------------------------------------------------------------
// rmcc_dp
// Datapath: player registers, angle lookup, step accumulators, map store,
// ceiling divider and result registers.
// ----------------------------------------------------------------------------
module rmcc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmcc_pkg::ctrl_cmd_t           cmd_i,
  output rmcc_pkg::dp_status_t          st_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [rmcc_pkg::POS_W-1:0]    cfg_data_i,
  input  logic [rmcc_pkg::CELL_W-1:0]   cell_index_i,
  input  logic [rmcc_pkg::VAL_W-1:0]    cell_value_i,
  input  logic [rmcc_pkg::COL_W-1:0]    column_i,
  output logic [rmcc_pkg::K_W-1:0]      step_count_o,
  output logic [rmcc_pkg::SHADE_W-1:0]  shade_o,
  output logic [rmcc_pkg::CEIL_W-1:0]   ceiling_row_o,
  output logic [rmcc_pkg::FLOOR_W-1:0]  floor_row_o,
  output logic                          wall_hit_o
);

  logic [rmcc_pkg::POS_W-1:0] px_r, py_r;
  logic [rmcc_pkg::ANG_W-1:0] pa_r;
  logic [rmcc_pkg::ANG_W-1:0] ang_r;
  logic signed [rmcc_pkg::TRIG_W-1:0] ex_r, ey_r;
  logic signed [rmcc_pkg::ACC_W-1:0] accx_r, accy_r;
  logic [rmcc_pkg::K_W-1:0] k_r, pend_k_r, res_k_r;
  logic pend_v_r, pend_off_r, hit_r;
  logic [rmcc_pkg::REM_W-1:0] rem_r;
  logic [rmcc_pkg::DEN_W-1:0] den_r;
  logic [rmcc_pkg::CEIL_W-1:0] q_r;
  logic [rmcc_pkg::CNT_W-1:0] cnt_r;

  logic signed [9:0] a_sum;
  logic [rmcc_pkg::ANG_W-1:0] a_wrap;
  logic signed [rmcc_pkg::PX_W-1:0] posx, posy;
  logic [7:0] tx, ty;
  logic off;
  logic [rmcc_pkg::CELL_W-1:0] raddr;
  logic rdata;
  logic term;
  logic [rmcc_pkg::REM_W-1:0] num, shifted;
  logic [9:0] k5, k3;

  // ray angle index
  always_comb begin
    a_sum = 10'(signed'({2'b00, pa_r})) + 10'(signed'({4'b0000, column_i}))
            - 10'(rmcc_pkg::WINDOW_WIDTH / 2);
    if (a_sum < 0) a_wrap = rmcc_pkg::ANG_W'(a_sum + 10'(rmcc_pkg::ANGLE_STEPS));
    else if (a_sum >= 10'(rmcc_pkg::ANGLE_STEPS))
      a_wrap = rmcc_pkg::ANG_W'(a_sum - 10'(rmcc_pkg::ANGLE_STEPS));
    else a_wrap = rmcc_pkg::ANG_W'(a_sum);
  end

  // position and map address of the step being issued
  always_comb begin
    posx = signed'({5'b00000, px_r}) + rmcc_pkg::PX_W'(accx_r >>> 7);
    posy = signed'({5'b00000, py_r}) + rmcc_pkg::PX_W'(accy_r >>> 7);
    tx = posx[15:8];
    ty = posy[15:8];
    off = posx[rmcc_pkg::PX_W-1] || posy[rmcc_pkg::PX_W-1]
          || (tx >= 8'(rmcc_pkg::MAP_WIDTH)) || (ty >= 8'(rmcc_pkg::MAP_HEIGHT));
    raddr = rmcc_pkg::CELL_W'(ty * 8'(rmcc_pkg::MAP_WIDTH) + tx);
  end

  rmcc_ram #(.WIDTH(1), .DEPTH(rmcc_pkg::MAP_CELLS)) u_map (
    .clk   (clk),
    .we    (cmd_i.accept_write && (8'(cell_index_i) < 8'(rmcc_pkg::MAP_CELLS))),
    .waddr (cell_index_i),
    .wdata (cell_value_i == rmcc_pkg::WALL_CODE),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign term = pend_v_r && (pend_off_r || rdata
                || (pend_k_r == rmcc_pkg::K_W'(rmcc_pkg::MAX_STEPS)));
  assign st_o.march_done = cmd_i.march && term;
  assign st_o.div_last = (cnt_r == '0);

  always_comb begin
    if (pend_k_r > rmcc_pkg::K_W'(4))
      num = rmcc_pkg::REM_W'(rmcc_pkg::WINDOW_HEIGHT) * rmcc_pkg::REM_W'(pend_k_r - 7'd4);
    else
      num = '0;
    shifted = rmcc_pkg::REM_W'(den_r) << cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r     <= 12'd1303;
      py_r     <= 12'd1715;
      pa_r     <= '0;
      pend_v_r <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rmcc_pkg::CFG_PLAYER_X:     px_r <= cfg_data_i;
          rmcc_pkg::CFG_PLAYER_Y:     py_r <= cfg_data_i;
          rmcc_pkg::CFG_PLAYER_ANGLE: pa_r <= cfg_data_i[rmcc_pkg::ANG_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load_angle) pend_v_r <= 1'b0;
      else if (cmd_i.march) pend_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.accept_cast) ang_r <= a_wrap;
    if (cmd_i.load_angle) begin
      ex_r   <= rmcc_pkg::COS_ROM[ang_r];
      ey_r   <= rmcc_pkg::SIN_ROM[ang_r];
      accx_r <= rmcc_pkg::ACC_W'(rmcc_pkg::COS_ROM[ang_r]);
      accy_r <= rmcc_pkg::ACC_W'(rmcc_pkg::SIN_ROM[ang_r]);
      k_r    <= rmcc_pkg::K_W'(1);
    end
    if (cmd_i.march) begin
      pend_k_r   <= k_r;
      pend_off_r <= off;
      k_r        <= k_r + 1'b1;
      accx_r     <= accx_r + rmcc_pkg::ACC_W'(ex_r);
      accy_r     <= accy_r + rmcc_pkg::ACC_W'(ey_r);
      if (term) begin
        res_k_r <= pend_k_r;
        hit_r   <= !pend_off_r && rdata;
        rem_r   <= num;
        den_r   <= rmcc_pkg::DEN_W'({pend_k_r, 1'b0});
        q_r     <= '0;
        cnt_r   <= rmcc_pkg::CNT_W'(rmcc_pkg::DIV_STEPS - 1);
      end
    end
    if (cmd_i.div_step) begin
      if (rem_r >= shifted) begin
        rem_r <= rem_r - shifted;
        q_r[cnt_r] <= 1'b1;
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign k5 = 10'(res_k_r) * 10'd5;
  assign k3 = 10'(res_k_r) * 10'd3;

  always_comb begin
    if (k5 <= 10'd32) shade_o = 2'd0;
    else if (k3 < 10'd32) shade_o = 2'd1;
    else if (res_k_r < 7'd32) shade_o = 2'd2;
    else shade_o = 2'd3;
  end

  assign step_count_o  = res_k_r;
  assign wall_hit_o    = hit_r;
  assign ceiling_row_o = q_r;
  assign floor_row_o   = rmcc_pkg::FLOOR_W'(rmcc_pkg::WINDOW_HEIGHT - 2) - 5'(q_r);

endmodule

// ===== design/rmcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmcc_ctrl
// Controller: accepts requests and sequences angle lookup, march and divide.
// ----------------------------------------------------------------------------
`include "ray_march_column_caster_macros.svh"

module rmcc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  op_i,
  output logic                  busy,
  output logic                  out_valid,
  output rmcc_pkg::ctrl_cmd_t   cmd_o,
  input  rmcc_pkg::dp_status_t  st_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_ANGLE, S_MARCH, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic   busy_r, out_valid_r;

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd_o.accept_write = start && !busy_r && (op_i == rmcc_pkg::OP_WRITE);
    cmd_o.accept_cast  = start && !busy_r && (op_i == rmcc_pkg::OP_CAST);
    cmd_o.load_angle   = (state_r == S_ANGLE);
    cmd_o.march        = (state_r == S_MARCH);
    cmd_o.div_step     = (state_r == S_DIV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_o.accept_cast) begin
            state_r <= S_ANGLE;
            busy_r  <= 1'b1;
          end
        end
        S_ANGLE: state_r <= S_MARCH;
        S_MARCH: begin
          if (st_i.march_done) state_r <= S_DIV;
        end
        S_DIV: begin
          if (st_i.div_last) begin
            state_r     <= S_OUT;
            out_valid_r <= 1'b1;
          end
        end
        S_OUT: begin
          state_r     <= S_IDLE;
          busy_r      <= 1'b0;
          out_valid_r <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `RMCC_ASSERT_IMPLY(a_out_while_busy, clk, rst_n, out_valid_r, busy_r)
  `RMCC_ASSERT_NEXT(a_out_single, clk, rst_n, out_valid_r, !out_valid_r)
  `RMCC_ASSERT_NEXT(a_cast_sets_busy, clk, rst_n, cmd_o.accept_cast, busy_r)
  `RMCC_ASSERT_NEXT(a_write_stays_idle, clk, rst_n, cmd_o.accept_write, !busy_r)

endmodule

// ===== design/ray_march_column_caster.sv =====
// ----------------------------------------------------------------------------
// ray_march_column_caster
// Map-based ray caster: loads wall cells and casts one screen column per
// request, returning step count, shade, ceiling row, floor row and hit flag.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a request is taken when start is high and busy is low.
//   in_op = 0 writes one map cell (in_cell_index, in_cell_value); it
//   produces no result and busy stays low.
//   in_op = 1 casts in_column. busy rises and stays high until the result
//   has been given; the step count k is 1..64. A cast runs angle table
//   lookup, then the march (one map RAM read per step, pipelined against
//   the wall test), then ceiling-row division and the output state.
//   Result: out_valid pulses for one cycle with the out_ fields; the
//   receiver cannot stall, so the result must be taken in that cycle.
//   Config: cfg_ready is always high; cfg_index 0/1/2 writes player x, y,
//   angle. Write only while busy is low.
//   Reset (rst_n low, synchronous): returns to idle, player registers take
//   their reset position; the map contents stay undefined until written.
// ----------------------------------------------------------------------------
module ray_march_column_caster (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [rmcc_pkg::CELL_W-1:0]   in_cell_index,
  input  logic [rmcc_pkg::VAL_W-1:0]    in_cell_value,
  input  logic [rmcc_pkg::COL_W-1:0]    in_column,
  output logic                          out_valid,
  output logic [rmcc_pkg::K_W-1:0]      out_step_count,
  output logic [rmcc_pkg::SHADE_W-1:0]  out_shade,
  output logic [rmcc_pkg::CEIL_W-1:0]   out_ceiling_row,
  output logic [rmcc_pkg::FLOOR_W-1:0]  out_floor_row,
  output logic                          out_wall_hit,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [rmcc_pkg::POS_W-1:0]    cfg_data
);

  rmcc_pkg::ctrl_cmd_t  cmd;
  rmcc_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  rmcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op_i      (in_op),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd_o     (cmd),
    .st_i      (st)
  );

  rmcc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .st_o          (st),
    .cfg_we_i      (cfg_valid && cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .cell_index_i  (in_cell_index),
    .cell_value_i  (in_cell_value),
    .column_i      (in_column),
    .step_count_o  (out_step_count),
    .shade_o       (out_shade),
    .ceiling_row_o (out_ceiling_row),
    .floor_row_o   (out_floor_row),
    .wall_hit_o    (out_wall_hit)
  );

endmodule

// ===== verif/tb_ray_march_column_caster.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_march_column_caster
// Self-checking bench for the column caster: loads the whole map, sweeps
// player position and heading, casts columns and checks every result
// against a local march predictor.
// ----------------------------------------------------------------------------
module tb_ray_march_column_caster;

  localparam int TIMEOUT_CYCLES = 700000;
  localparam int SETTLE_CYCLES  = 80;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [1:0] SHADE_NEAR = 2'd0;
  localparam logic [1:0] SHADE_MID  = 2'd1;
  localparam logic [1:0] SHADE_FAR  = 2'd2;
  localparam logic [1:0] SHADE_VOID = 2'd3;

  typedef struct packed {
    logic [rmcc_pkg::K_W-1:0]     steps;
    logic [rmcc_pkg::SHADE_W-1:0] shade;
    logic [rmcc_pkg::CEIL_W-1:0]  ceil_row;
    logic [rmcc_pkg::FLOOR_W-1:0] floor_row;
    logic                         hit;
  } column_t;

  class cast_scoreboard;
    bit  wall_bits [rmcc_pkg::MAP_CELLS];
    int  sin_tab [rmcc_pkg::ANGLE_STEPS];
    int  cos_tab [rmcc_pkg::ANGLE_STEPS];
    int  pos_x, pos_y, heading;
    column_t expected_columns [$];
    int  errors, casts, hits, writes;
    int  shade_seen [4];

    function new();
      int q, r, s_r, s_c;
      for (int i = 0; i < rmcc_pkg::ANGLE_STEPS; i++) begin
        q   = (4 * i) / rmcc_pkg::ANGLE_STEPS;
        r   = (4 * i) % rmcc_pkg::ANGLE_STEPS;
        s_r = quarter_wave(r);
        s_c = quarter_wave(rmcc_pkg::ANGLE_STEPS - r);
        case (q % 4)
          0:       begin sin_tab[i] = s_r;  cos_tab[i] = s_c;  end
          1:       begin sin_tab[i] = s_c;  cos_tab[i] = -s_r; end
          2:       begin sin_tab[i] = -s_r; cos_tab[i] = -s_c; end
          default: begin sin_tab[i] = -s_c; cos_tab[i] = s_r;  end
        endcase
      end
      pos_x   = 1303;
      pos_y   = 1715;
      heading = 0;
    endfunction

    function int quarter_wave(int r);
      longint unsigned x, x2, term;
      longint acc;
      x    = (longint'(r) * QUARTER_TURN_Q30) / rmcc_pkg::ANGLE_STEPS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      return int'((longint'(acc) + 32768) >>> 16);
    endfunction

    function void set_reg(rmcc_pkg::cfg_idx_t idx, logic [rmcc_pkg::POS_W-1:0] data);
      case (idx)
        rmcc_pkg::CFG_PLAYER_X:     pos_x = int'(data);
        rmcc_pkg::CFG_PLAYER_Y:     pos_y = int'(data);
        rmcc_pkg::CFG_PLAYER_ANGLE: heading = int'(data[rmcc_pkg::ANG_W-1:0]);
        default: ;
      endcase
    endfunction

    function column_t trace_column(int col);
      column_t c;
      int a, px, py, steps, ceil_row;
      bit hit;
      a = (heading + col - rmcc_pkg::WINDOW_WIDTH / 2) % rmcc_pkg::ANGLE_STEPS;
      if (a < 0) a += rmcc_pkg::ANGLE_STEPS;
      steps = rmcc_pkg::MAX_STEPS;
      hit   = 0;
      for (int k = 1; k <= rmcc_pkg::MAX_STEPS; k++) begin
        px = pos_x + ((cos_tab[a] * k) >>> 7);
        py = pos_y + ((sin_tab[a] * k) >>> 7);
        if (px < 0 || py < 0 || (px >> 8) >= rmcc_pkg::MAP_WIDTH
            || (py >> 8) >= rmcc_pkg::MAP_HEIGHT) begin
          steps = k;
          break;
        end
        if (wall_bits[(py >> 8) * rmcc_pkg::MAP_WIDTH + (px >> 8)]) begin
          steps = k;
          hit   = 1;
          break;
        end
      end
      c.steps = rmcc_pkg::K_W'(steps);
      if (steps * 5 <= 32) c.shade = SHADE_NEAR;
      else if (steps * 3 < 32) c.shade = SHADE_MID;
      else if (steps < 32) c.shade = SHADE_FAR;
      else c.shade = SHADE_VOID;
      ceil_row = (steps > 4) ? (rmcc_pkg::WINDOW_HEIGHT * (steps - 4)) / (2 * steps) : 0;
      c.ceil_row  = rmcc_pkg::CEIL_W'(ceil_row);
      c.floor_row = rmcc_pkg::FLOOR_W'(rmcc_pkg::WINDOW_HEIGHT - 2 - ceil_row);
      c.hit       = hit;
      return c;
    endfunction

    function void note_request(logic op, logic [rmcc_pkg::CELL_W-1:0] idx,
                               logic [rmcc_pkg::VAL_W-1:0] val,
                               logic [rmcc_pkg::COL_W-1:0] col);
      column_t c;
      if (op == rmcc_pkg::OP_WRITE) begin
        writes++;
        if (idx < rmcc_pkg::MAP_CELLS) wall_bits[idx] = (val == rmcc_pkg::WALL_CODE);
      end else begin
        c = trace_column(int'(col));
        casts++;
        hits += c.hit;
        shade_seen[c.shade]++;
        expected_columns.push_back(c);
      end
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(column_t got);
      column_t want;
      if (expected_columns.size() == 0) begin
        report_mismatch("unexpected result, step_count", got.steps, 0);
        return;
      end
      want = expected_columns.pop_front();
      if (got.steps !== want.steps) report_mismatch("step_count", got.steps, want.steps);
      if (got.shade !== want.shade) report_mismatch("shade", got.shade, want.shade);
      if (got.ceil_row !== want.ceil_row)
        report_mismatch("ceiling_row", got.ceil_row, want.ceil_row);
      if (got.floor_row !== want.floor_row)
        report_mismatch("floor_row", got.floor_row, want.floor_row);
      if (got.hit !== want.hit) report_mismatch("wall_hit", got.hit, want.hit);
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         in_op = rmcc_pkg::OP_WRITE;
  logic [rmcc_pkg::CELL_W-1:0]  in_cell_index = '0;
  logic [rmcc_pkg::VAL_W-1:0]   in_cell_value = '0;
  logic [rmcc_pkg::COL_W-1:0]   in_column = '0;
  logic                         out_valid;
  logic [rmcc_pkg::K_W-1:0]     out_step_count;
  logic [rmcc_pkg::SHADE_W-1:0] out_shade;
  logic [rmcc_pkg::CEIL_W-1:0]  out_ceiling_row;
  logic [rmcc_pkg::FLOOR_W-1:0] out_floor_row;
  logic                         out_wall_hit;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [1:0]                   cfg_index = rmcc_pkg::CFG_PLAYER_X;
  logic [rmcc_pkg::POS_W-1:0]   cfg_data = '0;

  cast_scoreboard sb = new();
  int cycle_count = 0;
  int gap_mode = 1;

  ray_march_column_caster dut (
    .clk, .rst_n, .start, .busy, .in_op, .in_cell_index, .in_cell_value, .in_column,
    .out_valid, .out_step_count, .out_shade, .out_ceiling_row, .out_floor_row,
    .out_wall_hit, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_op, in_cell_index, in_cell_value, in_column);
      if (out_valid)
        sb.check_result('{out_step_count, out_shade, out_ceiling_row, out_floor_row,
                          out_wall_hit});
    end
  end

  function int pick_gap();
    int roll;
    if (gap_mode == 0) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task send_request(logic op, logic [rmcc_pkg::CELL_W-1:0] idx,
                    logic [rmcc_pkg::VAL_W-1:0] val, logic [rmcc_pkg::COL_W-1:0] col);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_op         <= op;
    in_cell_index <= idx;
    in_cell_value <= val;
    in_column     <= col;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task hold_start_low();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task settle();
    hold_start_low();
    while (sb.expected_columns.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(rmcc_pkg::cfg_idx_t idx, logic [rmcc_pkg::POS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task load_map(int wall_pct);
    for (int i = 0; i < rmcc_pkg::MAP_CELLS; i++)
      send_request(rmcc_pkg::OP_WRITE, rmcc_pkg::CELL_W'(i), random_cell(wall_pct),
                   rmcc_pkg::COL_W'($urandom));
  endtask

  function logic [rmcc_pkg::VAL_W-1:0] random_cell(int wall_pct);
    logic [rmcc_pkg::VAL_W-1:0] v;
    if ($urandom_range(0, 99) < wall_pct) return rmcc_pkg::WALL_CODE;
    v = rmcc_pkg::VAL_W'($urandom);
    if (v == rmcc_pkg::WALL_CODE) v = 8'h0B;
    return v;
  endfunction

  function logic [rmcc_pkg::POS_W-1:0] random_pos(bit is_x);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (is_x) return rmcc_pkg::POS_W'($urandom_range(0, rmcc_pkg::MAP_WIDTH * 256 - 1));
    return rmcc_pkg::POS_W'($urandom_range(0, rmcc_pkg::MAP_HEIGHT * 256 - 1));
  endfunction

  function logic [rmcc_pkg::POS_W-1:0] random_heading();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 12'd0;
    if (roll == 1) return 12'd240;
    if (roll == 2) return rmcc_pkg::POS_W'($urandom);
    return rmcc_pkg::POS_W'($urandom_range(0, 255));
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty map first, then directed casts at extremes
    gap_mode = 0;
    load_map(0);
    send_request(rmcc_pkg::OP_CAST, '0, '0, 6'd0);
    send_request(rmcc_pkg::OP_CAST, '0, '0, 6'd39);
    send_request(rmcc_pkg::OP_CAST, '0, '0, 6'd63);
    send_request(rmcc_pkg::OP_CAST, '0, '0, 6'd20);
    send_request(rmcc_pkg::OP_WRITE, 7'd0, 8'hFF, '0);
    send_request(rmcc_pkg::OP_WRITE, 7'd127, rmcc_pkg::WALL_CODE, '0);
    send_request(rmcc_pkg::OP_WRITE, 7'd22, rmcc_pkg::WALL_CODE, '0);
    send_request(rmcc_pkg::OP_WRITE, 7'd21, 8'h00, '0);
    send_request(rmcc_pkg::OP_WRITE, 7'd23, 8'h09, '0);
    send_request(rmcc_pkg::OP_CAST, '0, '0, 6'd20);
    settle();
    write_reg(rmcc_pkg::CFG_PLAYER_X, 12'd0);
    write_reg(rmcc_pkg::CFG_PLAYER_Y, 12'd0);
    write_reg(rmcc_pkg::CFG_PLAYER_ANGLE, 12'd240);
    send_request(rmcc_pkg::OP_CAST, '0, '0, 6'd0);
    send_request(rmcc_pkg::OP_CAST, '0, '0, 6'd39);
    send_request(rmcc_pkg::OP_CAST, '0, '0, 6'd63);
    settle();
    write_reg(rmcc_pkg::CFG_PLAYER_X, 12'hFFF);
    write_reg(rmcc_pkg::CFG_PLAYER_Y, 12'hFFF);
    write_reg(rmcc_pkg::CFG_PLAYER_ANGLE, 12'hFFF);
    send_request(rmcc_pkg::OP_CAST, '0, '0, 6'd0);
    send_request(rmcc_pkg::OP_CAST, '0, '0, 6'd63);
    settle();

    for (int phase = 0; phase < 24; phase++) begin
      gap_mode = (phase % 5 == 2) ? 0 : 1;
      write_reg(rmcc_pkg::CFG_PLAYER_X, random_pos(1));
      write_reg(rmcc_pkg::CFG_PLAYER_Y, random_pos(0));
      write_reg(rmcc_pkg::CFG_PLAYER_ANGLE, random_heading());
      if (phase % 12 == 0) load_map($urandom_range(0, 40));
      repeat (21) begin
        if ($urandom_range(0, 99) < 25)
          send_request(rmcc_pkg::OP_WRITE, rmcc_pkg::CELL_W'($urandom), random_cell(15),
                       rmcc_pkg::COL_W'($urandom));
        else if ($urandom_range(0, 9) == 0)
          send_request(rmcc_pkg::OP_CAST, rmcc_pkg::CELL_W'($urandom),
                       rmcc_pkg::VAL_W'($urandom), rmcc_pkg::COL_W'($urandom));
        else
          send_request(rmcc_pkg::OP_CAST, rmcc_pkg::CELL_W'($urandom),
                       rmcc_pkg::VAL_W'($urandom),
                       rmcc_pkg::COL_W'($urandom_range(0, rmcc_pkg::WINDOW_WIDTH - 1)));
      end
      settle();
    end

    $display("casts %0d (wall hits %0d), map writes %0d", sb.casts, sb.hits, sb.writes);
    $display("shades near/mid/far/beyond: %0d/%0d/%0d/%0d, errors %0d", sb.shade_seen[0],
             sb.shade_seen[1], sb.shade_seen[2], sb.shade_seen[3], sb.errors);
    if (sb.errors == 0 && sb.expected_columns.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/rmcc_pkg.sv
design/rmcc_ram.sv
design/rmcc_dp.sv
design/rmcc_ctrl.sv
design/ray_march_column_caster.sv
verif/tb_ray_march_column_caster.sv
